[sv/ssi_pkg.sv]
// Package for the segment intersection pipeline: widths and constants.
// No dependencies.
package ssi_pkg;

  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned OutBits      = 32;

  // Stream packing widths for the default coordinate size
  localparam int unsigned InDataBits  = 8 * CoordBitsDef;
  localparam int unsigned OutDataBits = 2 * OutBits + 8;

endpackage

[sv/segment_segment_intersection.sv]
// Top level of the segment-segment intersection pipeline with output register.
// Depends on ssi_pkg, ssi_front and ssi_divider.
//
// Takes one segment pair per clock and returns one result per pair in order.
// There are 5 front stages (differences, cross products, normalization,
// numerator products, sign/magnitude), NBITS+FRAC_BITS+1 divider stages
// (a load stage plus one quotient bit each; 1 + 69 at defaults) and one output
// register. The whole pipeline advances when the output register is empty or
// being read, and s_axis_tready follows that same condition, so items stream
// back to back while the output is taken. A miss returns hit 0 with ix and iy
// zero; a hit returns Q(FRAC_BITS) truncated toward zero, wrapped to 32 bits.
module segment_segment_intersection import ssi_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // tdata: ax0, ay0, ax1, ay1, bx0, by0, bx1, by1 (lowest first)
  input  logic [8*CoordBits-1:0]    s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // tdata: hit, ix, iy (lowest first), zero padded
  output logic [OutDataBits-1:0]    m_axis_tdata
);

  localparam int unsigned DBits = CoordBits + 1;
  localparam int unsigned PBits = 2 * DBits + 1;
  localparam int unsigned NBits = PBits + CoordBits + 2;
  localparam int unsigned QBits = NBits + FracBits;
  localparam int unsigned SBits = 3;

  logic en;
  logic f_valid, f_hit, f_nx, f_ny;
  logic [NBits-1:0] f_mx, f_my;
  logic [PBits-1:0] f_den;

  // Output register, stall when full and not taken
  logic               ov_q;
  logic [OutBits-1:0] ox_q, oy_q;
  logic               oh_q;
  assign en            = !ov_q || m_axis_tready;
  assign s_axis_tready = en;

  ssi_front #(.CoordBits(CoordBits), .DBits(DBits),
              .PBits(PBits), .NBits(NBits)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .coord_i(s_axis_tdata),
    .valid_o(f_valid), .hit_o(f_hit), .negx_o(f_nx), .negy_o(f_ny),
    .magx_o(f_mx), .magy_o(f_my), .den_o(f_den)
  );

  // Numerators shifted by FracBits ahead of the divider
  logic [QBits-1:0] numx, numy, qx, qy;
  logic             dvx, dvy;
  logic [SBits-1:0] sx, sy;
  assign numx = {f_mx, {FracBits{1'b0}}} ;
  assign numy = {f_my, {FracBits{1'b0}}} ;

  ssi_divider #(.NumBits(QBits), .DenBits(PBits), .QBits(QBits), .SideBits(SBits))
  u_divx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .num_i(numx), .den_i(f_den),
    .side_i({f_hit, f_ny, f_nx}), .valid_o(dvx), .quo_o(qx), .side_o(sx)
  );
  ssi_divider #(.NumBits(QBits), .DenBits(PBits), .QBits(QBits), .SideBits(SBits))
  u_divy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .num_i(numy), .den_i(f_den),
    .side_i({f_hit, f_ny, f_nx}), .valid_o(dvy), .quo_o(qy), .side_o(sy)
  );

  logic [OutBits-1:0] rx, ry;
  always_comb begin
    rx = sx[0] ? OutBits'(-qx) : OutBits'(qx);
    ry = sx[1] ? OutBits'(-qy) : OutBits'(qy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= dvx;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      oh_q <= sx[2];
      ox_q <= sx[2] ? rx : '0;
      oy_q <= sx[2] ? ry : '0;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'b0, oy_q, ox_q, oh_q};

  // Both dividers march in lockstep
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni) dvx == dvy)
    else $error("divider valids diverged");
  a_side: assert property (@(posedge clk_i) disable iff (!rst_ni) dvx |-> sx == sy)
    else $error("divider sideband diverged");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !oh_q) |-> (ox_q == '0 && oy_q == '0))
    else $error("miss with nonzero point");

endmodule

[sv/ssi_divider.sv]
// Pipelined restoring divider: one quotient bit per stage.
// Depends on ssi_pkg. Each stage carries valid and sideband bits with the data.
module ssi_divider import ssi_pkg::*; #(
  parameter int unsigned NumBits = 64,
  parameter int unsigned DenBits = 48,
  parameter int unsigned QBits   = 48,
  parameter int unsigned SideBits = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [DenBits-1:0]  den_i,
  input  logic [SideBits-1:0] side_i,
  output logic                valid_o,
  output logic [QBits-1:0]    quo_o,
  output logic [SideBits-1:0] side_o
);

  // Numerator is shifted left by up to QBits; remainder stays below den.
  localparam int unsigned RemBits = DenBits + 1;
  localparam int unsigned NBits   = NumBits;

  logic [QBits:0]               vld_q;
  logic [RemBits-1:0]           rem_q [QBits+1];
  logic [NBits-1:0]             num_q [QBits+1];
  logic [DenBits-1:0]           den_q [QBits+1];
  logic [QBits-1:0]             quo_q [QBits+1];
  logic [SideBits-1:0]          side_q[QBits+1];

  // Stage zero: load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      num_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  // One quotient bit per stage; numerator bits beyond QBits are known zero here
  for (genvar s = 0; s < QBits; s++) begin : g_stage
    logic [RemBits:0]   trial;
    logic               take;
    logic [RemBits-1:0] rem_d;
    always_comb begin
      trial = {rem_q[s], num_q[s][NBits-1]};
      take  = trial >= {2'b00, den_q[s]};
      rem_d = take ? RemBits'(trial - {2'b00, den_q[s]}) : RemBits'(trial);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        num_q[s+1]  <= {num_q[s][NBits-2:0], 1'b0};
        den_q[s+1]  <= den_q[s];
        quo_q[s+1]  <= {quo_q[s][QBits-2:0], take};
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[QBits];
  assign quo_o   = quo_q[QBits];
  assign side_o  = side_q[QBits];

endmodule

[sv/ssi_front.sv]
// Front end: cross products, box and degenerate tests, fixed-point numerators.
// Depends on ssi_pkg. Five register stages; products are registered before reuse.
module ssi_front import ssi_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned DBits     = CoordBits + 1,
  parameter int unsigned PBits     = 2 * DBits + 1,
  parameter int unsigned NBits     = PBits + CoordBits + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [8*CoordBits-1:0] coord_i,
  output logic                  valid_o,
  output logic                  hit_o,
  output logic                  negx_o,
  output logic                  negy_o,
  output logic [NBits-1:0]      magx_o,
  output logic [NBits-1:0]      magy_o,
  output logic [PBits-1:0]      den_o
);

  logic signed [CoordBits-1:0] c [8];
  for (genvar k = 0; k < 8; k++) begin : g_unpack
    assign c[k] = coord_i[k*CoordBits +: CoordBits];
  end

  // Stage 1: differences and box test
  logic                      v1_q, box1_q;
  logic signed [DBits-1:0]   dax_q, day_q, dbx_q, dby_q, ex_q, ey_q;
  logic signed [CoordBits-1:0] ax0_q, ay0_q;
  logic signed [CoordBits-1:0] amnx, amxx, amny, amxy, bmnx, bmxx, bmny, bmxy;
  logic box_d;
  always_comb begin
    amnx = (c[0] < c[2]) ? c[0] : c[2];
    amxx = (c[0] > c[2]) ? c[0] : c[2];
    amny = (c[1] < c[3]) ? c[1] : c[3];
    amxy = (c[1] > c[3]) ? c[1] : c[3];
    bmnx = (c[4] < c[6]) ? c[4] : c[6];
    bmxx = (c[4] > c[6]) ? c[4] : c[6];
    bmny = (c[5] < c[7]) ? c[5] : c[7];
    bmxy = (c[5] > c[7]) ? c[5] : c[7];
    box_d = (amnx < bmxx) && (bmnx < amxx) && (amny < bmxy) && (bmny < amxy);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      box1_q <= box_d;
      dax_q  <= DBits'(c[2]) - DBits'(c[0]);
      day_q  <= DBits'(c[3]) - DBits'(c[1]);
      dbx_q  <= DBits'(c[6]) - DBits'(c[4]);
      dby_q  <= DBits'(c[7]) - DBits'(c[5]);
      ex_q   <= DBits'(c[4]) - DBits'(c[0]);
      ey_q   <= DBits'(c[5]) - DBits'(c[1]);
      ax0_q  <= c[0];
      ay0_q  <= c[1];
    end
  end

  // Stage 2: six products, degenerate tests
  logic v2_q, ok2_q;
  logic signed [PBits-1:0] p_ad_q, p_db_q, p_td_q, p_tb_q, p_ua_q, p_ub_q;
  logic signed [DBits-1:0] dax2_q, day2_q;
  logic signed [CoordBits-1:0] ax02_q, ay02_q;
  logic av, ah, bv, bh;
  always_comb begin
    av = dax_q == '0; ah = day_q == '0; bv = dbx_q == '0; bh = dby_q == '0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok2_q  <= box1_q && !(av && ah) && !(bv && bh) && !(av && bv) && !(ah && bh);
      p_ad_q <= PBits'(dax_q * dby_q);
      p_db_q <= PBits'(day_q * dbx_q);
      p_td_q <= PBits'(ex_q * dby_q);
      p_tb_q <= PBits'(ey_q * dbx_q);
      p_ua_q <= PBits'(ex_q * day_q);
      p_ub_q <= PBits'(ey_q * dax_q);
      dax2_q <= dax_q; day2_q <= day_q;
      ax02_q <= ax0_q; ay02_q <= ay0_q;
    end
  end

  // Stage 3: den, tn, un normalized to den > 0
  logic v3_q, ok3_q;
  logic signed [PBits-1:0] den3_q, tn3_q;
  logic signed [DBits-1:0] dax3_q, day3_q;
  logic signed [CoordBits-1:0] ax03_q, ay03_q;
  logic signed [PBits-1:0] den_s, tn_s, un_s, den_n, tn_n, un_n;
  always_comb begin
    den_s = p_ad_q - p_db_q;
    tn_s  = p_td_q - p_tb_q;
    un_s  = p_ua_q - p_ub_q;
    den_n = den_s[PBits-1] ? -den_s : den_s;
    tn_n  = den_s[PBits-1] ? -tn_s  : tn_s;
    un_n  = den_s[PBits-1] ? -un_s  : un_s;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en_i) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok3_q  <= ok2_q && (den_s != '0) && !tn_n[PBits-1] && (tn_n <= den_n)
                && !un_n[PBits-1] && (un_n <= den_n);
      den3_q <= den_n; tn3_q <= tn_n;
      dax3_q <= dax2_q; day3_q <= day2_q;
      ax03_q <= ax02_q; ay03_q <= ay02_q;
    end
  end

  // Stage 4: numerators base*den + d*tn (two products each)
  logic v4_q, ok4_q;
  logic signed [NBits-1:0] bx4_q, dx4_q, by4_q, dy4_q;
  logic [PBits-1:0] den4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en_i) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok4_q  <= ok3_q;
      bx4_q  <= NBits'(ax03_q * den3_q);
      dx4_q  <= NBits'(dax3_q * tn3_q);
      by4_q  <= NBits'(ay03_q * den3_q);
      dy4_q  <= NBits'(day3_q * tn3_q);
      den4_q <= den3_q;
    end
  end

  // Stage 5: sum, sign and magnitude
  logic signed [NBits-1:0] nx, ny;
  logic v5_q, ok5_q, nx5_q, ny5_q;
  logic [NBits-1:0] mx5_q, my5_q;
  logic [PBits-1:0] den5_q;
  always_comb begin
    nx = bx4_q + dx4_q;
    ny = by4_q + dy4_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en_i) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok5_q  <= ok4_q;
      nx5_q  <= nx[NBits-1];
      ny5_q  <= ny[NBits-1];
      mx5_q  <= nx[NBits-1] ? NBits'(-nx) : NBits'(nx);
      my5_q  <= ny[NBits-1] ? NBits'(-ny) : NBits'(ny);
      // keep divisor nonzero on misses so the divider stays benign
      den5_q <= ok4_q ? den4_q : PBits'(1);
    end
  end

  assign valid_o = v5_q;
  assign hit_o   = ok5_q;
  assign negx_o  = nx5_q;
  assign negy_o  = ny5_q;
  assign magx_o  = mx5_q;
  assign magy_o  = my5_q;
  assign den_o   = den5_q;

endmodule

[test/segment_segment_intersection_tb.sv]
// Testbench for segment_segment_intersection: streams segment pairs and checks each
// result against an exact integer predictor. Depends on ssi_pkg and the block.
`timescale 1ns / 1ps

module segment_segment_intersection_tb;
  import ssi_pkg::*;

  localparam int CB = CoordBitsDef;
  localparam int FB = FracBitsDef;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [31:0] iy;
    logic [31:0] ix;
    logic        hit;
  } isect_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [8*CB-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OutDataBits-1:0] m_axis_tdata;

  isect_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_hits = 0;
  int n_got = 0;
  bit stall_long = 0;

  segment_segment_intersection u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Cycle watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // base + d*tn/den in fixed point, truncated toward zero
  function automatic logic [31:0] to_fixed(longint base, longint d, longint tn, longint den);
    longint num;
    bit neg;
    longint unsigned mag, q, r, frac;
    num = base * den + d * tn;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    r = mag % den;
    frac = 0;
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      frac = frac << 1;
      if (r >= den) begin
        r -= den;
        frac |= 1;
      end
    end
    q = (q << FB) | frac;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  function automatic longint lo(longint a, longint b); return a < b ? a : b; endfunction
  function automatic longint hi(longint a, longint b); return a > b ? a : b; endfunction

  function automatic isect_t predict_isect(logic [8*CB-1:0] d);
    longint c[8];
    longint dax, day, dbx, dby, den, tn, un, ex, ey;
    isect_t res;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[i*CB +: CB]));
    res = '0;
    if (lo(c[0], c[2]) >= hi(c[4], c[6])) return res;
    if (lo(c[4], c[6]) >= hi(c[0], c[2])) return res;
    if (lo(c[1], c[3]) >= hi(c[5], c[7])) return res;
    if (lo(c[5], c[7]) >= hi(c[1], c[3])) return res;
    dax = c[2] - c[0]; day = c[3] - c[1];
    dbx = c[6] - c[4]; dby = c[7] - c[5];
    if ((dax == 0 && day == 0) || (dbx == 0 && dby == 0)) return res;
    if (dax == 0 && dbx == 0) return res;
    if (day == 0 && dby == 0) return res;
    den = dax * dby - day * dbx;
    if (den == 0) return res;
    ex = c[4] - c[0]; ey = c[5] - c[1];
    tn = ex * dby - ey * dbx;
    un = ex * day - ey * dax;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    if (tn < 0 || tn > den || un < 0 || un > den) return res;
    res.hit = 1;
    res.ix = to_fixed(c[0], dax, tn, den);
    res.iy = to_fixed(c[1], day, tn, den);
    return res;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 29) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // Send one segment pair; prediction is queued on acceptance.
  // tvalid stays high after the item so the next one can follow directly.
  task automatic send_pair(logic [8*CB-1:0] d, bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_isect(d));
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [8*CB-1:0] pack8(int a0, int b0, int a1, int b1,
                                            int c0, int d0, int c1, int d1);
    return {d1[CB-1:0], c1[CB-1:0], d0[CB-1:0], c0[CB-1:0],
            b1[CB-1:0], a1[CB-1:0], b0[CB-1:0], a0[CB-1:0]};
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    isect_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[64:0];
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        n_got++;
        if (exp_r.hit) n_hits++;
        if (got.hit !== exp_r.hit) begin
          $error("hit: expected %0d actual %0d", exp_r.hit, got.hit); errors++;
        end
        if (got.ix !== exp_r.ix) begin
          $error("ix: expected %h actual %h", exp_r.ix, got.ix); errors++;
        end
        if (got.iy !== exp_r.iy) begin
          $error("iy: expected %h actual %h", exp_r.iy, got.iy); errors++;
        end
      end
    end
  end

  // Receiver back-pressure
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (stall_long) m_axis_tready <= 1;
      else begin
        g = gap_len();
        if (g > 0) begin
          m_axis_tready <= 0;
          repeat (g) @(negedge clk_i);
        end
        m_axis_tready <= 1;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
    end
  end

  // Stop sending and wait until every expected result has come
  task automatic drain();
    s_axis_tvalid <= 0;
    @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    int mx, mn;
    mx = 32767; mn = -32768;
    send_pair(pack8(0, 0, 10, 10, 0, 10, 10, 0));         // plain cross
    send_pair(pack8(mn, mn, mx, mx, mn, mx, mx, mn));     // extreme diagonals
    send_pair(pack8(0, 0, 5, 5, 6, 0, 9, 9));             // boxes apart
    send_pair(pack8(0, 0, 5, 5, 5, 0, 9, 9));             // boxes touch
    send_pair(pack8(3, 3, 3, 3, 0, 0, 9, 9));             // point segment
    send_pair(pack8(0, 0, 9, 9, 4, 4, 4, 4));             // point second
    send_pair(pack8(2, 0, 2, 9, 3, 0, 3, 9));             // both vertical
    send_pair(pack8(0, 2, 9, 2, 0, 3, 9, 3));             // both horizontal
    send_pair(pack8(0, 0, 8, 4, 0, 1, 8, 5));             // parallel
    send_pair(pack8(0, 0, 8, 8, 2, 2, 10, 10));           // collinear overlap
    send_pair(pack8(4, -5, 4, 5, -5, 1, 5, -2));          // vertical and oblique
    send_pair(pack8(-5, 1, 5, 1, -3, -7, 4, 9));          // horizontal and oblique
    send_pair(pack8(4, -5, 4, 5, -5, 1, 5, 1));           // vertical vs horizontal
    send_pair(pack8(0, 0, 10, 10, 10, 0, 5, 5));          // endpoint touch
    send_pair(pack8(0, 0, 10, 1, 3, 5, 8, 4));            // lines cross outside
    send_pair(pack8(-7, -3, 2, 8, 1, -9, -6, 5));         // negative fractions
    send_pair(pack8(mn, 0, mx, 1, 0, mn, 1, mx));         // large numerators
    send_pair(pack8(mx, mn, mn, mx, mn, mn, mx, mx));
  endtask

  task automatic test_random(int count);
    logic [8*CB-1:0] d;
    int s, cx, cy;
    for (int i = 0; i < count; i++) begin
      d = {$urandom, $urandom, $urandom, $urandom};
      s = $urandom_range(0, 9);
      if (s < 5) begin
        // small crossing pairs around a random center, mostly hits
        cx = $signed(16'($urandom)) / 2; cy = $signed(16'($urandom)) / 2;
        d = pack8(cx - $urandom_range(0, 200), cy - $urandom_range(0, 200),
                  cx + $urandom_range(0, 200), cy + $urandom_range(0, 200),
                  cx - $urandom_range(0, 200), cy + $urandom_range(0, 200),
                  cx + $urandom_range(0, 200), cy - $urandom_range(0, 200));
      end else if (s == 5) begin
        // shared coordinates to hit vertical, horizontal and point cases
        d[2*CB +: CB] = d[0 +: CB];
        if ($urandom_range(0, 1)) d[6*CB +: CB] = d[4*CB +: CB];
        if ($urandom_range(0, 1)) d[7*CB +: CB] = d[5*CB +: CB];
      end
      send_pair(d, i % 300 > 40);
      if (i == count / 2) begin
        drain();
        stall_long = 1;
        repeat (20) send_pair({$urandom, $urandom, $urandom, $urandom}, 0);
        stall_long = 0;
      end
    end
  endtask

  task automatic test_pause();
    drain();
    repeat (10) send_pair({$urandom, $urandom, $urandom, $urandom});
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    test_directed();
    test_pause();
    test_random(1720);
    drain();
    repeat (100) @(negedge clk_i);
    $display("Sent %0d segment pairs, %0d results checked, %0d of them hits.",
             n_sent, n_got, n_hits);
    if (errors == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[segment_segment_intersection.f]
sv/ssi_pkg.sv
sv/ssi_divider.sv
sv/ssi_front.sv
sv/segment_segment_intersection.sv
test/segment_segment_intersection_tb.sv
